// ===== rtl/sensor_frame_crc_checker_macros.svh =====
// assertion macros for the sensor frame crc checker
`ifndef SENSOR_FRAME_CRC_CHECKER_MACROS_SVH
`define SENSOR_FRAME_CRC_CHECKER_MACROS_SVH

`ifndef ASSERT_OFF
// clocked check, masked during reset
`define SFCC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that also holds during reset
`define SFCC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFCC_ASSERT(label, clk, rst, prop, msg)
`define SFCC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== rtl/sfcc_pkg.sv =====
// types, constants and the crc-8 byte update for the sensor frame checker
package sfcc_pkg;

  localparam logic [7:0]  CRC_INIT       = 8'hFF;
  localparam logic [7:0]  CRC_POLY       = 8'h31;
  localparam logic [3:0]  FRAME_LEN      = 4'd9;
  localparam logic [3:0]  LAST_POS       = 4'd8;
  localparam logic [31:0] MAX_CONC_RESET = 32'd50000;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_CRC   = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  localparam logic [1:0] WORD_NONE = 2'd0;
  localparam logic [1:0] WORD_CONC_HI = 2'd1;
  localparam logic [1:0] WORD_CONC_LO = 2'd2;
  localparam logic [1:0] WORD_TEMP = 2'd3;

  typedef struct packed {
    logic        done;
    status_t     status;
    logic [1:0]  bad_crc_index;
    logic [31:0] concentration;
    logic [15:0] temperature_raw;
  } result_t;

  // msb-first crc-8, no reflection, no final xor
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/sfcc_if.sv =====
// valid/ready channels of the sensor frame checker
interface sfcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;
  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface sfcc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  bad_crc_index;
  logic [31:0] concentration;
  logic [15:0] temperature_raw;
  modport source (output valid, output status, output bad_crc_index,
                  output concentration, output temperature_raw, input ready);
  modport sink (input valid, input status, input bad_crc_index,
                input concentration, input temperature_raw, output ready);
endinterface

interface sfcc_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/sfcc_frame.sv =====
// frame tracker: byte position, running crc, field assembly and final status
module sfcc_frame (
  input  logic              clk,
  input  logic              rst,
  input  logic              beat,
  input  logic [7:0]        rx_byte,
  input  logic              frame_start,
  input  logic [31:0]       max_concentration,
  output sfcc_pkg::result_t result
);

  logic [3:0]  byte_position, byte_position_next, pos_cur;
  logic [7:0]  running_crc, running_crc_next, crc_cur;
  logic [31:0] conc_shift, conc_shift_next, conc_cur;
  logic [15:0] temp_shift, temp_shift_next, temp_cur;
  logic [1:0]  first_bad, first_bad_next, bad_cur, word_idx;

  always_comb begin
    // a frame start restarts everything before this byte is applied
    pos_cur  = frame_start ? 4'd0 : byte_position;
    crc_cur  = frame_start ? sfcc_pkg::CRC_INIT : running_crc;
    conc_cur = frame_start ? 32'd0 : conc_shift;
    temp_cur = frame_start ? 16'd0 : temp_shift;
    bad_cur  = frame_start ? sfcc_pkg::WORD_NONE : first_bad;

    byte_position_next = byte_position;
    running_crc_next   = running_crc;
    conc_shift_next    = conc_shift;
    temp_shift_next    = temp_shift;
    first_bad_next     = first_bad;
    result.done        = 1'b0;

    unique case (pos_cur)
      4'd2:    word_idx = sfcc_pkg::WORD_CONC_HI;
      4'd5:    word_idx = sfcc_pkg::WORD_CONC_LO;
      default: word_idx = sfcc_pkg::WORD_TEMP;
    endcase

    if (beat) begin
      byte_position_next = pos_cur;
      running_crc_next   = crc_cur;
      conc_shift_next    = conc_cur;
      temp_shift_next    = temp_cur;
      first_bad_next     = bad_cur;
      if (pos_cur < sfcc_pkg::FRAME_LEN) begin
        unique case (pos_cur)
          4'd0, 4'd1, 4'd3, 4'd4: begin
            conc_shift_next  = {conc_cur[23:0], rx_byte};
            running_crc_next = sfcc_pkg::crc8_byte(crc_cur, rx_byte);
          end
          4'd6, 4'd7: begin
            temp_shift_next  = {temp_cur[7:0], rx_byte};
            running_crc_next = sfcc_pkg::crc8_byte(crc_cur, rx_byte);
          end
          default: begin
            // check byte closes a word
            if (crc_cur != rx_byte && bad_cur == sfcc_pkg::WORD_NONE) begin
              first_bad_next = word_idx;
            end
            running_crc_next = sfcc_pkg::CRC_INIT;
          end
        endcase
        byte_position_next = pos_cur + 4'd1;
        result.done        = (pos_cur == sfcc_pkg::LAST_POS);
      end
    end

    result.bad_crc_index   = first_bad_next;
    result.concentration   = conc_shift_next;
    result.temperature_raw = temp_shift_next;
    priority if (first_bad_next != sfcc_pkg::WORD_NONE) begin
      result.status = sfcc_pkg::STATUS_CRC;
    end else if (conc_shift_next == 32'd0 || conc_shift_next > max_concentration) begin
      result.status = sfcc_pkg::STATUS_RANGE;
    end else begin
      result.status = sfcc_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= sfcc_pkg::FRAME_LEN;
      running_crc   <= sfcc_pkg::CRC_INIT;
      conc_shift    <= 32'd0;
      temp_shift    <= 16'd0;
      first_bad     <= sfcc_pkg::WORD_NONE;
    end else begin
      byte_position <= byte_position_next;
      running_crc   <= running_crc_next;
      conc_shift    <= conc_shift_next;
      temp_shift    <= temp_shift_next;
      first_bad     <= first_bad_next;
    end
  end

endmodule

// ===== rtl/sensor_frame_crc_checker.sv =====
// sensor frame checker top level: config register, frame tracker, result register
//
// rx carries one frame byte per beat, with frame_start marking byte 0 of a frame.
// a frame is nine bytes: three 16-bit words, each followed by a crc-8 byte
// (poly 0x31, init 0xff). after the ninth byte one beat appears on res with the
// status, the first failing word, the 32-bit concentration and 16-bit temperature.
// bytes past the ninth, and bytes before any frame start, are dropped silently.
// cfg writes max_concentration; ready is always high, write only while idle.
// throughput: one byte per cycle unless res stalls; the crc update and range compare
// sit in one stage between the frame state registers and the result register.
// latency: the result beat is valid the cycle after the ninth byte is taken.
// when res stalls, the result register holds and rx.ready drops until it is
// taken; rx.ready is high whenever the result register is empty or draining.
// reset (rst, synchronous) empties the result register, sets max_concentration
// to 50000 and leaves the tracker waiting for a frame start.
`include "sensor_frame_crc_checker_macros.svh"

module sensor_frame_crc_checker (
  input logic        clk,
  input logic        rst,
  sfcc_in_if.sink    rx,
  sfcc_out_if.source res,
  sfcc_cfg_if.sink   cfg
);

  logic              rx_beat;
  logic [31:0]       max_concentration;
  logic              res_valid;
  sfcc_pkg::result_t frame_result;
  sfcc_pkg::result_t res_data;

  assign cfg.ready = 1'b1;
  assign rx.ready  = !res_valid || res.ready;
  assign rx_beat   = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_concentration <= sfcc_pkg::MAX_CONC_RESET;
    end else if (cfg.valid && cfg.ready) begin
      max_concentration <= cfg.data;
    end
  end

  sfcc_frame u_frame (
    .clk               (clk),
    .rst               (rst),
    .beat              (rx_beat),
    .rx_byte           (rx.rx_byte),
    .frame_start       (rx.frame_start),
    .max_concentration (max_concentration),
    .result            (frame_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (rx_beat) begin
      res_valid <= frame_result.done;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_beat && frame_result.done) begin
      res_data <= frame_result;
    end
  end

  assign res.valid           = res_valid;
  assign res.status          = res_data.status;
  assign res.bad_crc_index   = res_data.bad_crc_index;
  assign res.concentration   = res_data.concentration;
  assign res.temperature_raw = res_data.temperature_raw;

  `SFCC_ASSERT(a_no_take_when_stalled, clk, rst,
    res_valid && !res.ready |-> !rx_beat, "byte taken while result stalled")
  `SFCC_ASSERT(a_index_matches_status, clk, rst,
    res_valid |-> ((res.status == sfcc_pkg::STATUS_CRC) ==
                   (res.bad_crc_index != sfcc_pkg::WORD_NONE)),
    "bad_crc_index disagrees with status")
  `SFCC_ASSERT(a_result_from_beat, clk, rst,
    $rose(res_valid) |-> $past(rx_beat), "result appeared without a byte")

endmodule
